// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("never");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== sv/fbcm_pkg.sv =====
// Package: sizes, codes and chain table reset values
`default_nettype none
package fbcm_pkg;
   localparam int NUM_BLOCKS = 256;
   localparam int ROOT_ENTRIES = 16;
   localparam int FIRST_DATA_BLOCK = 4;
   localparam int EFF_BLOCKS = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
   localparam int ENTRY_BITS = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1;
   localparam int NAME_W = 40;

   typedef logic [7:0] block_type;
   typedef logic [2:0] status_type;
   typedef logic [2:0] req_code_type;

   localparam req_code_type REQ_CREATE = 3'd0;
   localparam req_code_type REQ_REMOVE = 3'd1;
   localparam req_code_type REQ_FIRST  = 3'd2;
   localparam req_code_type REQ_APPEND = 3'd3;
   localparam req_code_type REQ_DELETE = 3'd4;
   localparam req_code_type REQ_NEXT   = 3'd5;

   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_EXISTS      = 3'd1;
   localparam status_type ST_DIR_FULL    = 3'd2;
   localparam status_type ST_NO_FILE     = 3'd3;
   localparam status_type ST_NOT_EMPTY   = 3'd4;
   localparam status_type ST_DISK_FULL   = 3'd5;
   localparam status_type ST_NOT_IN_FILE = 3'd6;

   localparam block_type FREE_HEAD_RESET =
      (FIRST_DATA_BLOCK < EFF_BLOCKS) ? block_type'(FIRST_DATA_BLOCK) : 8'd0;

   function automatic block_type reset_link(input logic [8:0] blk);
      if (int'(blk) >= FIRST_DATA_BLOCK && int'(blk) + 1 < EFF_BLOCKS)
         reset_link = block_type'(blk + 9'd1);
      else
         reset_link = 8'd0;
   endfunction

   function automatic logic in_range(input block_type blk);
      in_range = (int'(blk) < EFF_BLOCKS);
   endfunction
endpackage
`default_nettype wire

// ===== sv/fat_block_chain_manager.sv =====
// Top level: sequencer over the directory and the chain table
// Each known request scans the directory, then walks the chain table for append, delete and next;
// unknown request codes are answered from idle; a delete ends with a write that frees the block.
// One transaction at a time; busy drops no later than the cycle after the result strobe.
// After reset a fill sweep loads every chain table entry; busy stays high meanwhile.
`default_nettype none
`include "assert_macros.svh"
module fat_block_chain_manager (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire fbcm_pkg::req_code_type req_type,
   input  wire logic [fbcm_pkg::NAME_W-1:0] req_file_name,
   input  wire fbcm_pkg::block_type req_block_number,
   output logic rsp_valid,
   output fbcm_pkg::status_type rsp_status,
   output fbcm_pkg::block_type rsp_block_out
);
   import fbcm_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_OP   = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;
   localparam logic [2:0] S_STEP = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_FIN2 = 3'd7;

   logic [2:0] state_ff, state_in;
   block_type head_in;
   logic out_in;
   req_code_type req_ff;
   logic [NAME_W-1:0] name_ff;
   block_type bn_ff, cur_ff, prev_ff, head_ff, alloc_ff;
   logic [ENTRY_BITS:0] idx_ff;
   logic [ENTRY_BITS-1:0] hit_ff, free_ff;
   logic hit_found_ff, free_found_ff;
   logic [8:0] steps_ff;
   status_type st_ff;
   block_type bo_ff;
   logic out_ff;

   logic init_done;
   logic [ENTRY_BITS-1:0] d_rd_idx;
   logic d_valid;
   logic [NAME_W-1:0] d_name;
   block_type d_first;
   logic d_wr, d_wr_valid, d_wr_name;
   block_type d_wr_first;
   block_type t_rd_addr, t_rd_data, t_wr_addr, t_wr_data;
   logic t_wr;

   fbcm_dir u_dir (
      .clock(clock), .reset(reset), .rd_idx(d_rd_idx), .rd_valid(d_valid),
      .rd_name(d_name), .rd_first(d_first), .wr_en(d_wr), .wr_idx(hit_ff),
      .wr_valid(d_wr_valid), .wr_name_en(d_wr_name), .wr_name(name_ff),
      .wr_first(d_wr_first)
   );

   fbcm_table u_table (
      .clock(clock), .reset(reset), .init_done(init_done), .rd_addr(t_rd_addr),
      .rd_data(t_rd_data), .wr_en(t_wr), .wr_addr(t_wr_addr), .wr_data(t_wr_data)
   );

   assign busy = (state_ff != S_IDLE) || !init_done;
   assign rsp_valid = out_ff;
   assign rsp_status = st_ff;
   assign rsp_block_out = bo_ff;
   assign d_rd_idx = (state_ff == S_SCAN) ? idx_ff[ENTRY_BITS-1:0] : hit_ff;

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      out_in = 1'b0;
      d_wr = 1'b0;
      d_wr_valid = d_valid;
      d_wr_name = 1'b0;
      d_wr_first = d_first;
      t_rd_addr = cur_ff;
      t_wr = 1'b0;
      t_wr_addr = cur_ff;
      t_wr_data = 8'd0;
      case (state_ff)
         S_IDLE: if (start && init_done) begin
            if (req_type > REQ_NEXT) out_in = 1'b1;
            else state_in = S_SCAN;
         end
         S_SCAN: if (int'(idx_ff) == ROOT_ENTRIES - 1 ||
                     (d_valid && d_name == name_ff)) state_in = S_OP;
         S_OP: begin
            state_in = S_FIN;
            if (req_ff == REQ_CREATE) begin
               if (!hit_found_ff && free_found_ff) begin
                  d_wr = 1'b1;
                  d_wr_valid = 1'b1;
                  d_wr_name = 1'b1;
                  d_wr_first = 8'd0;
               end
            end else if (!hit_found_ff) begin
               state_in = S_FIN;
            end else if (req_ff == REQ_REMOVE) begin
               if (d_first == 8'd0) begin
                  d_wr = 1'b1;
                  d_wr_valid = 1'b0;
               end
            end else if (req_ff == REQ_APPEND) begin
               if (head_ff != 8'd0 && in_range(head_ff)) begin
                  t_rd_addr = head_ff;
                  state_in = S_RD;
               end
            end else if (req_ff == REQ_DELETE || req_ff == REQ_NEXT) begin
               if (bn_ff != 8'd0 && in_range(bn_ff) && d_first != 8'd0 &&
                   in_range(d_first)) begin
                  t_rd_addr = d_first;
                  state_in = S_WAIT;
               end
            end
         end
         S_RD: begin
            head_in = t_rd_data;
            t_wr = 1'b1;
            t_wr_addr = alloc_ff;
            t_wr_data = 8'd0;
            if (d_first == 8'd0) begin
               d_wr = 1'b1;
               d_wr_first = alloc_ff;
               state_in = S_FIN;
            end else begin
               t_rd_addr = d_first;
               state_in = S_STEP;
            end
         end
         S_WAIT: begin
            if (cur_ff == bn_ff) begin
               state_in = S_FIN;
               if (req_ff == REQ_DELETE) begin
                  if (prev_ff == 8'd0) begin
                     d_wr = 1'b1;
                     d_wr_first = t_rd_data;
                  end else begin
                     t_wr = 1'b1;
                     t_wr_addr = prev_ff;
                     t_wr_data = t_rd_data;
                  end
                  state_in = S_FIN2;
               end
            end else if (t_rd_data == 8'd0 || !in_range(t_rd_data) ||
                         int'(steps_ff) + 1 >= EFF_BLOCKS) begin
               state_in = S_FIN;
            end else begin
               t_rd_addr = t_rd_data;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (req_ff == REQ_APPEND) begin
               if (t_rd_data == 8'd0 || !in_range(t_rd_data) ||
                   int'(steps_ff) >= EFF_BLOCKS) begin
                  t_wr = 1'b1;
                  t_wr_addr = cur_ff;
                  t_wr_data = alloc_ff;
                  state_in = S_FIN;
               end else begin
                  t_rd_addr = t_rd_data;
               end
            end else begin
               state_in = S_WAIT;
            end
         end
         S_FIN2: begin
            t_wr = 1'b1;
            t_wr_addr = cur_ff;
            t_wr_data = head_ff;
            head_in = cur_ff;
            out_in = 1'b1;
            state_in = S_IDLE;
         end
         S_FIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_in == S_FIN && state_ff != S_FIN) out_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= FREE_HEAD_RESET;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            req_ff <= req_type;
            name_ff <= req_file_name;
            bn_ff <= req_block_number;
            idx_ff <= '0;
            hit_found_ff <= 1'b0;
            free_found_ff <= 1'b0;
            hit_ff <= '0;
            free_ff <= '0;
            st_ff <= ST_OK;
            bo_ff <= 8'd0;
         end
         S_SCAN: begin
            idx_ff <= idx_ff + 1'b1;
            if (d_valid && d_name == name_ff) begin
               hit_found_ff <= 1'b1;
               hit_ff <= idx_ff[ENTRY_BITS-1:0];
            end else if (!d_valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_ff <= idx_ff[ENTRY_BITS-1:0];
            end
            if (state_in == S_OP && req_ff == REQ_CREATE &&
                !(d_valid && d_name == name_ff)) begin
               if (!d_valid && !free_found_ff) hit_ff <= idx_ff[ENTRY_BITS-1:0];
               else hit_ff <= free_ff;
            end
         end
         S_OP: begin
            prev_ff <= 8'd0;
            steps_ff <= 9'd0;
            alloc_ff <= head_ff;
            cur_ff <= d_first;
            if (req_ff == REQ_CREATE) begin
               st_ff <= hit_found_ff ? ST_EXISTS :
                        (free_found_ff ? ST_OK : ST_DIR_FULL);
            end else if (!hit_found_ff) begin
               st_ff <= ST_NO_FILE;
            end else if (req_ff == REQ_REMOVE) begin
               st_ff <= (d_first != 8'd0) ? ST_NOT_EMPTY : ST_OK;
            end else if (req_ff == REQ_FIRST) begin
               bo_ff <= d_first;
            end else if (req_ff == REQ_APPEND) begin
               if (head_ff == 8'd0 || !in_range(head_ff)) st_ff <= ST_DISK_FULL;
               else bo_ff <= head_ff;
            end else begin
               st_ff <= ST_NOT_IN_FILE;
            end
         end
         S_WAIT: begin
            if (cur_ff == bn_ff) begin
               st_ff <= ST_OK;
               if (req_ff == REQ_NEXT) bo_ff <= t_rd_data;
            end else begin
               prev_ff <= cur_ff;
               cur_ff <= t_rd_data;
               steps_ff <= steps_ff + 9'd1;
            end
         end
         S_STEP: if (req_ff == REQ_APPEND && state_in != S_FIN) begin
            cur_ff <= t_rd_data;
            steps_ff <= steps_ff + 9'd1;
         end
         default: st_ff <= st_ff;
      endcase
   end

   `ASSERT_NEVER(a_no_start_when_uninit, clock, reset, out_ff && !init_done)
   `ASSERT_IMPL(a_rsp_one_cycle, clock, reset, (out_ff && state_ff != S_IDLE) |=> !out_ff)
   `ASSERT_IMPL(a_rsp_then_idle, clock, reset, out_ff |-> state_ff == S_IDLE || state_ff == S_FIN)
   `ASSERT_NEVER(a_table_write_during_idle, clock, reset, t_wr && state_ff == S_IDLE)
endmodule
`default_nettype wire

// ===== sv/fbcm_dir.sv =====
// Root directory: entry registers, one entry compared per cycle by the sequencer
`default_nettype none
module fbcm_dir (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [fbcm_pkg::ENTRY_BITS-1:0] rd_idx,
   output logic rd_valid,
   output logic [fbcm_pkg::NAME_W-1:0] rd_name,
   output fbcm_pkg::block_type rd_first,
   input  wire logic wr_en,
   input  wire logic [fbcm_pkg::ENTRY_BITS-1:0] wr_idx,
   input  wire logic wr_valid,
   input  wire logic wr_name_en,
   input  wire logic [fbcm_pkg::NAME_W-1:0] wr_name,
   input  wire fbcm_pkg::block_type wr_first
);
   import fbcm_pkg::*;
   logic [ROOT_ENTRIES-1:0] valid_ff;
   logic [NAME_W-1:0] name_ff [ROOT_ENTRIES];
   block_type first_ff [ROOT_ENTRIES];

   assign rd_valid = valid_ff[rd_idx];
   assign rd_name = name_ff[rd_idx];
   assign rd_first = first_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < ROOT_ENTRIES; i++) first_ff[i] <= 8'd0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= wr_valid;
         first_ff[wr_idx] <= wr_first;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_name_en) name_ff[wr_idx] <= wr_name;
   end
endmodule
`default_nettype wire

// ===== sv/fbcm_table.sv =====
// Chain table memory with registered read and a reset fill sweep
`default_nettype none
module fbcm_table (
   input  wire logic clock,
   input  wire logic reset,
   output logic init_done,
   input  wire fbcm_pkg::block_type rd_addr,
   output fbcm_pkg::block_type rd_data,
   input  wire logic wr_en,
   input  wire fbcm_pkg::block_type wr_addr,
   input  wire fbcm_pkg::block_type wr_data
);
   import fbcm_pkg::*;
   block_type mem [EFF_BLOCKS];
   logic [8:0] sweep_ff;
   logic done_ff;
   logic [8:0] sweep_in;

   assign init_done = done_ff;
   assign sweep_in = sweep_ff + 9'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= 9'd0;
         done_ff <= 1'b0;
      end else if (!done_ff) begin
         sweep_ff <= sweep_in;
         if (int'(sweep_in) == EFF_BLOCKS) done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!done_ff) mem[sweep_ff[7:0]] <= reset_link(sweep_ff);
      else if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
